// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, ante, cons, msg)

`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/tiws_pkg.sv =====
`default_nettype none

package tiws_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned FRACTION_BITS = 16;

  // one guard slot below the table, two above
  localparam int unsigned SLOT_COUNT = TABLE_ENTRIES + 3;
  localparam int unsigned BANKS      = 4;
  localparam int unsigned BANK_W     = 2;
  localparam int unsigned ROWS       = (SLOT_COUNT + BANKS - 1) / BANKS;
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned IDX_W      = $clog2(TABLE_ENTRIES);

  localparam int unsigned ADDR_W     = 11;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned INV_W      = 31;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned FRAC_W     = FRACTION_BITS;

  // input modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // register indexes
  localparam logic [1:0] REG_START_POINT  = 2'd0;
  localparam logic [1:0] REG_END_POINT    = 2'd1;
  localparam logic [1:0] REG_INVERSE_STEP = 2'd2;

  // scaled position d * inverse_step
  localparam int unsigned POS_W = DATA_W + INV_W;
  localparam int unsigned HI_W  = POS_W - 2 * FRACTION_BITS;

  // differences of samples
  localparam int unsigned G_W    = DATA_W + 1;
  localparam int unsigned HG_W   = DATA_W + 2;
  localparam int unsigned CURV_W = DATA_W + 3;

  // products and sums of the value and slope terms
  localparam int unsigned FCURV_W = CURV_W + FRAC_W;
  localparam int unsigned FHG_W   = HG_W + FRAC_W;
  localparam int unsigned INNER_W = FCURV_W + 1;
  localparam int unsigned BLEND_W = FHG_W + 1;
  localparam int unsigned VPROD_W = INNER_W + FRAC_W;
  localparam int unsigned BLO_W   = BLEND_W / 2;
  localparam int unsigned BHI_W   = BLEND_W - BLO_W;
  localparam int unsigned PLO_W   = BLO_W + INV_W;
  localparam int unsigned PHI_W   = BHI_W + INV_W;
  localparam int unsigned SPROD_W = BLEND_W + INV_W;
  localparam int unsigned SHIFT   = 2 * FRACTION_BITS + 1;
  localparam int unsigned VSUM_W  = VPROD_W - SHIFT + 1;
  localparam int unsigned SLOPE_W = SPROD_W - SHIFT;

  localparam int unsigned PIPE_STAGES = 11;

  typedef struct packed {
    logic [DATA_W-1:0] start_point;
    logic [DATA_W-1:0] end_point;
    logic [INV_W-1:0]  inverse_step;
  } tiws_cfg_t;

  typedef struct packed {
    logic [PIPE_STAGES:1] load;
    logic                 mem_write;
  } tiws_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/tiws_addr.sv =====
`default_nettype none

module tiws_addr (
  input  logic                          clk_i,
  input  tiws_pkg::tiws_ctrl_t          ctrl_i,
  input  tiws_pkg::tiws_cfg_t           cfg_i,
  input  logic [tiws_pkg::DATA_W-1:0]   argument_i,
  input  logic [tiws_pkg::ADDR_W-1:0]   entry_address_i,
  input  logic [tiws_pkg::DATA_W-1:0]   entry_data_i,
  output logic [tiws_pkg::IDX_W-1:0]    idx_o,
  output logic [tiws_pkg::FRAC_W-1:0]   frac_o,
  output logic                          clamped_o,
  output logic [tiws_pkg::ADDR_W-1:0]   waddr_o,
  output logic [tiws_pkg::DATA_W-1:0]   wdata_o
);
  import tiws_pkg::*;

  // stage 1: clamp
  logic              arg_lt, arg_gt;
  logic [DATA_W-1:0] pos1_d, pos1_q;
  logic              clamped1_q;
  logic [ADDR_W-1:0] waddr1_q;
  logic [DATA_W-1:0] wdata1_q;

  always_comb begin
    arg_lt = $signed(argument_i) < $signed(cfg_i.start_point);
    arg_gt = $signed(argument_i) > $signed(cfg_i.end_point);
    priority if (arg_lt) begin
      pos1_d = cfg_i.start_point;
    end else if (arg_gt) begin
      pos1_d = cfg_i.end_point;
    end else begin
      pos1_d = argument_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      pos1_q     <= pos1_d;
      clamped1_q <= arg_lt | arg_gt;
      waddr1_q   <= entry_address_i;
      wdata1_q   <= entry_data_i;
    end
  end

  // stage 2: distance above start
  logic [DATA_W:0]   diff2;
  logic [DATA_W-1:0] dist2_q;
  logic              neg2_q, clamped2_q;
  logic [ADDR_W-1:0] waddr2_q;
  logic [DATA_W-1:0] wdata2_q;

  assign diff2 = {pos1_q[DATA_W-1], pos1_q}
               - {cfg_i.start_point[DATA_W-1], cfg_i.start_point};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      dist2_q    <= diff2[DATA_W-1:0];
      neg2_q     <= diff2[DATA_W];
      clamped2_q <= clamped1_q;
      waddr2_q   <= waddr1_q;
      wdata2_q   <= wdata1_q;
    end
  end

  // stage 3: scale by the inverse step
  logic [POS_W-1:0]  scaled3_d, scaled3_q;
  logic              neg3_q, clamped3_q;
  logic [ADDR_W-1:0] waddr3_q;
  logic [DATA_W-1:0] wdata3_q;

  assign scaled3_d = POS_W'(dist2_q) * POS_W'(cfg_i.inverse_step);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      scaled3_q  <= scaled3_d;
      neg3_q     <= neg2_q;
      clamped3_q <= clamped2_q;
      waddr3_q   <= waddr2_q;
      wdata3_q   <= wdata2_q;
    end
  end

  // stage 4: index and fraction, zero below start, index saturates at the top
  logic [HI_W-1:0]   hi4;
  logic [IDX_W-1:0]  idx4_d, idx4_q;
  logic [FRAC_W-1:0] frac4_d, frac4_q;
  logic              clamped4_q;
  logic [ADDR_W-1:0] waddr4_q;
  logic [DATA_W-1:0] wdata4_q;

  assign hi4 = scaled3_q[POS_W-1:2*FRACTION_BITS];

  always_comb begin
    priority if (neg3_q) begin
      idx4_d  = '0;
      frac4_d = '0;
    end else if (hi4 > HI_W'(TABLE_ENTRIES - 1)) begin
      idx4_d  = IDX_W'(TABLE_ENTRIES - 1);
      frac4_d = '0;
    end else begin
      idx4_d  = hi4[IDX_W-1:0];
      frac4_d = scaled3_q[2*FRACTION_BITS-1:FRACTION_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[4]) begin
      idx4_q     <= idx4_d;
      frac4_q    <= frac4_d;
      clamped4_q <= clamped3_q;
      waddr4_q   <= waddr3_q;
      wdata4_q   <= wdata3_q;
    end
  end

  assign idx_o     = idx4_q;
  assign frac_o    = frac4_q;
  assign clamped_o = clamped4_q;
  assign waddr_o   = waddr4_q;
  assign wdata_o   = wdata4_q;

endmodule

`default_nettype wire

// ===== hdl/tiws_table.sv =====
`default_nettype none

module tiws_table (
  input  logic                                clk_i,
  input  tiws_pkg::tiws_ctrl_t                ctrl_i,
  input  logic [tiws_pkg::IDX_W-1:0]          idx_i,
  input  logic [tiws_pkg::FRAC_W-1:0]         frac_i,
  input  logic                                clamped_i,
  input  logic [tiws_pkg::ADDR_W-1:0]         waddr_i,
  input  logic [tiws_pkg::DATA_W-1:0]         wdata_i,
  output logic signed [tiws_pkg::DATA_W-1:0]  c_o,
  output logic signed [tiws_pkg::G_W-1:0]     g_o,
  output logic signed [tiws_pkg::HG_W-1:0]    hg_o,
  output logic signed [tiws_pkg::CURV_W-1:0]  curv_o,
  output logic [tiws_pkg::FRAC_W-1:0]         frac_o,
  output logic                                zero_o,
  output logic                                clamped_o
);
  import tiws_pkg::*;

  // slots are interleaved over four banks, so the four neighbors of any
  // index sit in four different banks and are read in the same cycle
  logic              wr_in_range;
  logic [BANK_W-1:0] wr_bank;
  logic [ROW_W-1:0]  wr_row;

  assign wr_in_range = 32'(waddr_i) < 32'(SLOT_COUNT);
  assign wr_bank     = waddr_i[BANK_W-1:0];
  assign wr_row      = ROW_W'(waddr_i >> BANK_W);

  logic [DATA_W-1:0] rd5_q [BANKS];

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    logic [DATA_W-1:0] mem_q [ROWS];
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;

    // banks below the rotation point hold the slot from the next row
    assign rd_row = ROW_W'(idx_i >> BANK_W)
                  + ROW_W'(BANK_W'(k) < idx_i[BANK_W-1:0]);
    assign wr_en  = ctrl_i.mem_write && wr_in_range && (wr_bank == BANK_W'(k));

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        mem_q[wr_row] <= wdata_i;
      end
      if (ctrl_i.load[5]) begin
        rd5_q[k] <= mem_q[rd_row];
      end
    end
  end

  logic [BANK_W-1:0] rot5_q;
  logic [FRAC_W-1:0] frac5_q;
  logic              zero5_q, clamped5_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[5]) begin
      rot5_q     <= idx_i[BANK_W-1:0];
      frac5_q    <= frac_i;
      zero5_q    <= (idx_i == '0);
      clamped5_q <= clamped_i;
    end
  end

  // stage 6: undo the bank rotation and form the differences
  logic signed [DATA_W-1:0] s_m, s_c, s_p, s_q;
  logic signed [G_W-1:0]    g6_d, h6_d;
  logic signed [HG_W-1:0]   hg6_d;
  logic signed [CURV_W-1:0] curv6_d;

  always_comb begin
    unique case (rot5_q)
      2'd0: begin
        s_m = rd5_q[0]; s_c = rd5_q[1]; s_p = rd5_q[2]; s_q = rd5_q[3];
      end
      2'd1: begin
        s_m = rd5_q[1]; s_c = rd5_q[2]; s_p = rd5_q[3]; s_q = rd5_q[0];
      end
      2'd2: begin
        s_m = rd5_q[2]; s_c = rd5_q[3]; s_p = rd5_q[0]; s_q = rd5_q[1];
      end
      default: begin
        s_m = rd5_q[3]; s_c = rd5_q[0]; s_p = rd5_q[1]; s_q = rd5_q[2];
      end
    endcase
    g6_d    = G_W'(s_p) - G_W'(s_m);
    h6_d    = G_W'(s_q) - G_W'(s_c);
    hg6_d   = HG_W'(h6_d) - HG_W'(g6_d);
    curv6_d = CURV_W'(s_p) + CURV_W'(s_m) - (CURV_W'(s_c) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[6]) begin
      c_o       <= s_c;
      g_o       <= g6_d;
      hg_o      <= hg6_d;
      curv_o    <= curv6_d;
      frac_o    <= frac5_q;
      zero_o    <= zero5_q;
      clamped_o <= clamped5_q;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tiws_arith.sv =====
`default_nettype none

module tiws_arith (
  input  logic                                clk_i,
  input  tiws_pkg::tiws_ctrl_t                ctrl_i,
  input  logic [tiws_pkg::INV_W-1:0]          inverse_step_i,
  input  logic signed [tiws_pkg::DATA_W-1:0]  c_i,
  input  logic signed [tiws_pkg::G_W-1:0]     g_i,
  input  logic signed [tiws_pkg::HG_W-1:0]    hg_i,
  input  logic signed [tiws_pkg::CURV_W-1:0]  curv_i,
  input  logic [tiws_pkg::FRAC_W-1:0]         frac_i,
  input  logic                                zero_i,
  input  logic                                clamped_i,
  output logic [tiws_pkg::DATA_W-1:0]         interp_value_o,
  output logic [tiws_pkg::DATA_W-1:0]         slope_value_o,
  output logic                                was_clamped_o
);
  import tiws_pkg::*;

  localparam int unsigned SAT_W = (VSUM_W > SLOPE_W) ? VSUM_W : SLOPE_W;

  function automatic logic [DATA_W-1:0] sat_word(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-DATA_W:0] top_bits;
    top_bits = x[SAT_W-1:DATA_W-1];
    if (top_bits == '0 || top_bits == '1) begin
      return x[DATA_W-1:0];
    end else if (x[SAT_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // stage 7: fraction times curvature and times difference of differences
  logic signed [FRAC_W:0]    frac6_s;
  logic signed [FCURV_W-1:0] fcurv7_d, fcurv7_q;
  logic signed [FHG_W-1:0]   fhg7_d, fhg7_q;
  logic signed [G_W-1:0]     g7_q;
  logic signed [DATA_W-1:0]  c7_q;
  logic [FRAC_W-1:0]         frac7_q;
  logic                      zero7_q, clamped7_q;

  assign frac6_s  = $signed({1'b0, frac_i});
  assign fcurv7_d = curv_i * frac6_s;
  assign fhg7_d   = hg_i * frac6_s;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[7]) begin
      fcurv7_q   <= fcurv7_d;
      fhg7_q     <= fhg7_d;
      g7_q       <= g_i;
      c7_q       <= c_i;
      frac7_q    <= frac_i;
      zero7_q    <= zero_i;
      clamped7_q <= clamped_i;
    end
  end

  // stage 8: add the first difference
  logic signed [INNER_W-1:0] inner8_d, inner8_q;
  logic signed [BLEND_W-1:0] blend8_d, blend8_q;
  logic signed [DATA_W-1:0]  c8_q;
  logic [FRAC_W-1:0]         frac8_q;
  logic                      zero8_q, clamped8_q;

  assign inner8_d = INNER_W'(fcurv7_q) + (INNER_W'(g7_q) <<< FRACTION_BITS);
  assign blend8_d = BLEND_W'(fhg7_q) + (BLEND_W'(g7_q) <<< FRACTION_BITS);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[8]) begin
      inner8_q   <= inner8_d;
      blend8_q   <= blend8_d;
      c8_q       <= c7_q;
      frac8_q    <= frac7_q;
      zero8_q    <= zero7_q;
      clamped8_q <= clamped7_q;
    end
  end

  // stage 9: second fraction product, slope product split in two halves
  logic signed [FRAC_W:0]    frac8_s;
  logic signed [INV_W:0]     inv_s;
  logic signed [VPROD_W-1:0] vprod9_d, vprod9_q;
  logic [PLO_W-1:0]          plo9_d, plo9_q;
  logic signed [PHI_W-1:0]   phi9_d, phi9_q;
  logic signed [DATA_W-1:0]  c9_q;
  logic                      zero9_q, clamped9_q;

  assign frac8_s  = $signed({1'b0, frac8_q});
  assign inv_s    = $signed({1'b0, inverse_step_i});
  assign vprod9_d = inner8_q * frac8_s;
  assign plo9_d   = blend8_q[BLO_W-1:0] * inverse_step_i;
  assign phi9_d   = $signed(blend8_q[BLEND_W-1:BLO_W]) * inv_s;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[9]) begin
      vprod9_q   <= vprod9_d;
      plo9_q     <= plo9_d;
      phi9_q     <= phi9_d;
      c9_q       <= c8_q;
      zero9_q    <= zero8_q;
      clamped9_q <= clamped8_q;
    end
  end

  // stage 10: floor scaling by dropping low bits, value gets the center sample
  logic signed [SPROD_W-1:0] plo9_ext, sprod10;
  logic signed [VSUM_W-1:0]  vsum10_d, vsum10_q;
  logic signed [SLOPE_W-1:0] slope10_q;
  logic                      zero10_q, clamped10_q;

  assign plo9_ext = $signed(SPROD_W'(plo9_q));
  assign sprod10  = (SPROD_W'(phi9_q) <<< BLO_W) + plo9_ext;
  assign vsum10_d = VSUM_W'($signed(vprod9_q[VPROD_W-1:SHIFT])) + VSUM_W'(c9_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[10]) begin
      vsum10_q    <= vsum10_d;
      slope10_q   <= $signed(sprod10[SPROD_W-1:SHIFT]);
      zero10_q    <= zero9_q;
      clamped10_q <= clamped9_q;
    end
  end

  // stage 11: saturate into the output register, slope is zero at index 0
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[11]) begin
      interp_value_o <= sat_word(SAT_W'(vsum10_q));
      slope_value_o  <= zero10_q ? '0 : sat_word(SAT_W'(slope10_q));
      was_clamped_o  <= clamped10_q;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/table_interp_with_slope.sv =====
// table_interp_with_slope: quadratic interpolation of an evenly spaced table,
// with its slope, in signed Q16.16.
// input channel: in_valid_i / in_stall_o carry one transaction per cycle while
// in_stall_o is low; mode_i low writes entry_data_i to slot entry_address_i,
// mode_i high evaluates at argument_i. a write yields no result, an evaluation
// exactly one result on out_valid_o / out_stall_i, in input order.
// configuration: apb port, start_point at 0x0, end_point at 0x4,
// inverse_step at 0x8; write only while no transaction is in flight.
// pipeline: 11 stages; an accepted evaluation enters the stage 1 register and its
// result shows on the outputs from the stage 11 register. throughput one
// transaction per cycle while in_stall_o is low; a 4-bank table is read in
// stage 5 and the multipliers sit in stages 3, 7 and 9.
// writes land in the table at stage 5, so they order exactly with evaluations.
// reset clears the pipeline and sets start 0, end 0, inverse_step 1.0;
// table contents stay undefined until written.
// when the receiver stalls, the result holds in the output register and the
// pipeline keeps filling its empty stages; in_stall_o rises only once every
// stage holds a transaction.
`default_nettype none

module table_interp_with_slope (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [tiws_pkg::ADDR_W-1:0]     entry_address_i,
  input  logic [tiws_pkg::DATA_W-1:0]     entry_data_i,
  input  logic [tiws_pkg::DATA_W-1:0]     argument_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tiws_pkg::DATA_W-1:0]     interp_value_o,
  output logic [tiws_pkg::DATA_W-1:0]     slope_value_o,
  output logic                            was_clamped_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tiws_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tiws_pkg::*;

  `include "assert_macros.svh"

  localparam logic [INV_W-1:0] INV_STEP_RESET = INV_W'(65536);

  // configuration registers
  tiws_cfg_t  cfg_q;
  logic       cfg_write;
  logic [1:0] cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_point  <= '0;
      cfg_q.end_point    <= '0;
      cfg_q.inverse_step <= INV_STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_START_POINT:  cfg_q.start_point  <= pwdata;
        REG_END_POINT:    cfg_q.end_point    <= pwdata;
        REG_INVERSE_STEP: cfg_q.inverse_step <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_START_POINT:  prdata = cfg_q.start_point;
      REG_END_POINT:    prdata = cfg_q.end_point;
      REG_INVERSE_STEP: prdata = {1'b0, cfg_q.inverse_step};
      default:          prdata = '0;
    endcase
  end

  // pipeline control: a stage loads when it is empty or its successor loads
  logic [PIPE_STAGES:1]   valid_q;
  logic [4:1]             eval_q;
  logic [PIPE_STAGES+1:1] load;
  tiws_ctrl_t             ctrl;

  assign load[PIPE_STAGES+1] = !out_stall_i;
  for (genvar k = 1; k <= PIPE_STAGES; k++) begin : g_load
    assign load[k] = !valid_q[k] || load[k+1];
  end

  assign ctrl.load      = load[PIPE_STAGES:1];
  assign ctrl.mem_write = valid_q[4] && !eval_q[4] && load[5];

  assign in_stall_o  = !load[1];
  assign out_valid_o = valid_q[PIPE_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      eval_q  <= '0;
    end else begin
      if (load[1]) begin
        valid_q[1] <= in_valid_i;
        eval_q[1]  <= (mode_i == MODE_EVAL);
      end
      for (int k = 2; k <= 4; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
          eval_q[k]  <= eval_q[k-1];
        end
      end
      // a table write ends at the memory stage
      if (load[5]) begin
        valid_q[5] <= valid_q[4] && eval_q[4];
      end
      for (int k = 6; k <= PIPE_STAGES; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  logic [IDX_W-1:0]          a_idx;
  logic [FRAC_W-1:0]         a_frac;
  logic                      a_clamped;
  logic [ADDR_W-1:0]         a_waddr;
  logic [DATA_W-1:0]         a_wdata;

  tiws_addr u_addr (
    .clk_i           (clk_i),
    .ctrl_i          (ctrl),
    .cfg_i           (cfg_q),
    .argument_i      (argument_i),
    .entry_address_i (entry_address_i),
    .entry_data_i    (entry_data_i),
    .idx_o           (a_idx),
    .frac_o          (a_frac),
    .clamped_o       (a_clamped),
    .waddr_o         (a_waddr),
    .wdata_o         (a_wdata)
  );

  logic signed [DATA_W-1:0]  t_c;
  logic signed [G_W-1:0]     t_g;
  logic signed [HG_W-1:0]    t_hg;
  logic signed [CURV_W-1:0]  t_curv;
  logic [FRAC_W-1:0]         t_frac;
  logic                      t_zero;
  logic                      t_clamped;

  tiws_table u_table (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .idx_i     (a_idx),
    .frac_i    (a_frac),
    .clamped_i (a_clamped),
    .waddr_i   (a_waddr),
    .wdata_i   (a_wdata),
    .c_o       (t_c),
    .g_o       (t_g),
    .hg_o      (t_hg),
    .curv_o    (t_curv),
    .frac_o    (t_frac),
    .zero_o    (t_zero),
    .clamped_o (t_clamped)
  );

  tiws_arith u_arith (
    .clk_i          (clk_i),
    .ctrl_i         (ctrl),
    .inverse_step_i (cfg_q.inverse_step),
    .c_i            (t_c),
    .g_i            (t_g),
    .hg_i           (t_hg),
    .curv_i         (t_curv),
    .frac_i         (t_frac),
    .zero_i         (t_zero),
    .clamped_i      (t_clamped),
    .interp_value_o (interp_value_o),
    .slope_value_o  (slope_value_o),
    .was_clamped_o  (was_clamped_o)
  );

  `ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, valid_q[1], "accepted transaction did not enter stage 1")
  `ASSERT_IMPLIES(a_free_flow, !out_stall_i, !in_stall_o, "input stalled while output is free")
  `ASSERT_NEXT(a_write_retires, ctrl.mem_write, !valid_q[5], "table write produced a result")
  `ASSERT_NEXT(a_mem_stage_holds, valid_q[5] && !load[6], valid_q[5], "blocked transaction lost at stage 5")

endmodule

`default_nettype wire
